>>> hdl/gbsp_pkg.sv
// Shared codes and fixed widths for the grid BFS shortest-path block.
package gbsp_pkg;

  localparam int DIMS    = 4;   // coordinate fields per item
  localparam int SIZE_W  = 17;  // extent and coordinate field width
  localparam int COORD_W = 16;  // stored 0-based coordinate width
  localparam int DIST_W  = 16;
  localparam int ADDR_W  = 4;   // APB byte address width

  typedef enum logic [0:0] {
    ACT_LOAD  = 1'b0,
    ACT_SOLVE = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NOWAY = 2'd1,
    ST_WALL  = 2'd2,
    ST_BAD   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_SIZE0 = 2'd0,
    REG_SIZE1 = 2'd1,
    REG_SIZE2 = 2'd2,
    REG_SIZE3 = 2'd3
  } reg_idx_t;

endpackage

>>> hdl/gbsp_if.sv
// Handshake channels: input item and result item.
interface gbsp_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  action;
  logic [9:0]  word_index;
  logic [63:0] wall_bits;
  logic [16:0] start_c0;
  logic [16:0] start_c1;
  logic [16:0] start_c2;
  logic [16:0] start_c3;
  logic [16:0] end_c0;
  logic [16:0] end_c1;
  logic [16:0] end_c2;
  logic [16:0] end_c3;
  modport source (output valid, action, word_index, wall_bits, start_c0, start_c1,
                  start_c2, start_c3, end_c0, end_c1, end_c2, end_c3, input ready);
  modport sink (input valid, action, word_index, wall_bits, start_c0, start_c1,
                start_c2, start_c3, end_c0, end_c1, end_c2, end_c3, output ready);
endinterface

interface gbsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] distance;
  modport source (output valid, status, distance, input ready);
  modport sink (input valid, status, distance, output ready);
endinterface

>>> hdl/gbsp_mul.sv
// Shared registered multiplier used for stride and cell index setup.
module gbsp_mul #(
  parameter int AW = 17,
  parameter int BW = 17
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule

>>> hdl/grid_bfs_shortest_path.sv
// Top level: grid BFS shortest path with wall map, visited map and frontier queue.
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------
//  in_ch   | in  | action, word_index, wall_bits, start_c0..3, end_c0..3
//  out_ch  | out | status, distance (one beat per solve, none per load)
//  apb     | in  | size_dim0..3 at byte address 4*i
//
//  A load beat writes one wall-map word. A solve runs index setup, wall checks
//  on start and end, a visited-map clear and a seed, then for each cell popped
//  a read and check of every neighbor in range.
//  rst_n is synchronous; walls are undefined until loaded. in_ch.ready is low
//  from a solve until its result beat is taken; out_ch stalls hold the result.
module grid_bfs_shortest_path #(
  parameter int MAX_CELLS = 65536
) (
  input  logic                      clk,
  input  logic                      rst_n,
  gbsp_in_if.sink                   in_ch,
  gbsp_out_if.source                out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [gbsp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  localparam int CELL_W    = $clog2(MAX_CELLS);
  localparam int MAP_WORDS = (MAX_CELLS + 63) / 64;
  localparam int WORD_W    = (CELL_W > 6) ? CELL_W - 6 : 1;
  localparam int CNT_W     = CELL_W + 1;
  localparam int PW        = gbsp_pkg::SIZE_W + CNT_W;
  localparam int CW        = gbsp_pkg::COORD_W;
  localparam int QW        = CELL_W + gbsp_pkg::DIMS * CW;

  typedef enum logic [3:0] {
    S_IDLE, S_DIM, S_WS_RD, S_WS_CHK, S_WE_RD, S_WE_CHK, S_CLEAR, S_SEED,
    S_POP_RD, S_POP_CHK, S_NB_RD, S_NB_CHK, S_NEXT, S_DONE
  } state_t;

  state_t state_r;

  // ---- configuration registers ----
  logic [gbsp_pkg::SIZE_W-1:0] size_r [gbsp_pkg::DIMS];
  logic [1:0] reg_sel;
  assign reg_sel = paddr[3:2];
  assign pready  = 1'b1;
  assign prdata  = 32'(size_r[reg_sel]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gbsp_pkg::DIMS; i++) size_r[i] <= 17'd1;
    end else if (psel && penable && pwrite) begin
      size_r[reg_sel] <= pwdata[gbsp_pkg::SIZE_W-1:0];
    end
  end

  // ---- solve working registers ----
  logic [gbsp_pkg::SIZE_W-1:0] sc_r [gbsp_pkg::DIMS];
  logic [gbsp_pkg::SIZE_W-1:0] ec_r [gbsp_pkg::DIMS];
  logic [CNT_W-1:0]  stride_r [gbsp_pkg::DIMS];
  logic [CNT_W-1:0]  cells_r;
  logic [CELL_W-1:0] start_r, end_r, nb_r;
  logic [1:0]        dim_r, sub_r;
  logic [2:0]        cand_r;
  logic [CNT_W-1:0]  head_r, tail_r, left_r, queued_r, level_r;
  logic [WORD_W:0]   clr_r;
  logic [QW-1:0]     cur_r;
  logic [1:0]        status_r;
  logic [gbsp_pkg::DIST_W-1:0] dist_r;

  // ---- shared multiplier ----
  logic [gbsp_pkg::SIZE_W-1:0] mul_a;
  logic [PW-1:0]               mul_p;
  always_comb begin
    case (sub_r)
      2'd0:    mul_a = sc_r[dim_r] - 17'd1;
      2'd1:    mul_a = ec_r[dim_r] - 17'd1;
      default: mul_a = size_r[dim_r];
    endcase
  end
  gbsp_mul #(.AW(gbsp_pkg::SIZE_W), .BW(CNT_W)) u_mul (
    .clk(clk), .a(mul_a), .b(cells_r), .p_r(mul_p)
  );

  // per-dimension validity of size and coordinates
  logic [gbsp_pkg::SIZE_W-1:0] sz_c, sc_c, ec_c;
  logic dim_bad;
  assign sz_c = size_r[dim_r];
  assign sc_c = sc_r[dim_r];
  assign ec_c = ec_r[dim_r];
  assign dim_bad = (sz_c == '0) || (sz_c[16] && (sz_c[15:0] != '0)) ||
                   (sc_c == '0) || (sc_c > sz_c) || (ec_c == '0) || (ec_c > sz_c);

  // ---- neighbor candidate: dimension cand_r[2:1], minus when cand_r[0] ----
  logic [1:0]        nd;
  logic [CW-1:0]     ncoord;
  logic              n_ok;
  logic [CELL_W-1:0] nb_c;
  logic [CELL_W-1:0] cur_cell;
  assign cur_cell = cur_r[CELL_W-1:0];
  assign nd       = cand_r[2:1];
  assign ncoord   = cur_r[CELL_W + 32'(nd) * CW +: CW];
  assign n_ok     = cand_r[0] ? (ncoord != '0)
                              : ({1'b0, ncoord} + 17'd1 < size_r[nd]);
  assign nb_c     = cand_r[0] ? cur_cell - stride_r[nd][CELL_W-1:0]
                              : cur_cell + stride_r[nd][CELL_W-1:0];

  // ---- memories ----
  logic [63:0] wall_mem [MAP_WORDS];
  logic [63:0] vis_mem  [MAP_WORDS];
  logic [QW-1:0] q_mem  [MAX_CELLS];
  logic [63:0] wall_q_r, vis_q_r;
  logic [QW-1:0] q_q_r;

  logic [WORD_W-1:0] rd_word;
  always_comb begin
    case (state_r)
      S_WS_RD: rd_word = WORD_W'(start_r >> 6);
      S_WE_RD: rd_word = WORD_W'(end_r >> 6);
      S_NB_RD: rd_word = WORD_W'(nb_c >> 6);
      default: rd_word = '0;
    endcase
  end

  logic in_acc, load_we, nb_free, nb_hit, nb_push;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign load_we = in_acc && (in_ch.action == gbsp_pkg::ACT_LOAD) &&
                   (32'(in_ch.word_index) < MAP_WORDS);
  assign nb_free = !(wall_q_r[nb_r[5:0]] || vis_q_r[nb_r[5:0]]);
  assign nb_hit  = nb_free && (nb_r == end_r);
  assign nb_push = (state_r == S_NB_CHK) && nb_free && !nb_hit;

  always_ff @(posedge clk) begin
    if (load_we) wall_mem[WORD_W'(in_ch.word_index)] <= in_ch.wall_bits;
    wall_q_r <= wall_mem[rd_word];
  end

  logic              vis_we;
  logic [WORD_W-1:0] vis_wa;
  logic [63:0]       vis_wd;
  always_comb begin
    vis_we = 1'b0;
    vis_wa = WORD_W'(nb_r >> 6);
    vis_wd = vis_q_r | (64'd1 << nb_r[5:0]);
    case (state_r)
      S_CLEAR: begin
        vis_we = 1'b1;
        vis_wa = clr_r[WORD_W-1:0];
        vis_wd = '0;
      end
      S_SEED: begin
        vis_we = 1'b1;
        vis_wa = WORD_W'(start_r >> 6);
        vis_wd = 64'd1 << start_r[5:0];
      end
      default: vis_we = nb_push;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q_r <= vis_mem[rd_word];
  end

  // queue entry: cell index, then 0-based coordinate of each dimension
  logic          q_we;
  logic [QW-1:0] q_wd;
  always_comb begin
    q_wd = cur_r;
    q_wd[CELL_W-1:0] = nb_r;
    q_wd[CELL_W + 32'(nd) * CW +: CW] = cand_r[0] ? ncoord - 16'd1 : ncoord + 16'd1;
    q_we = nb_push;
    if (state_r == S_SEED) begin
      q_we = 1'b1;
      q_wd[CELL_W-1:0] = start_r;
      for (int i = 0; i < gbsp_pkg::DIMS; i++)
        q_wd[CELL_W + i * CW +: CW] = CW'(sc_r[i] - 17'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[tail_r[CELL_W-1:0]] <= q_wd;
    q_q_r <= q_mem[head_r[CELL_W-1:0]];
  end

  // saturate the level count to the distance field
  function automatic logic [gbsp_pkg::DIST_W-1:0] sat_dist(input logic [CNT_W-1:0] v);
    if (v > CNT_W'(16'hFFFF)) sat_dist = 16'hFFFF;
    else sat_dist = v[gbsp_pkg::DIST_W-1:0];
  endfunction

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = (state_r == S_DONE);
  assign out_ch.status   = status_r;
  assign out_ch.distance = dist_r;

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      dim_r    <= '0;
      sub_r    <= '0;
      cand_r   <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      left_r   <= '0;
      queued_r <= '0;
      level_r  <= '0;
      clr_r    <= '0;
      cells_r  <= '0;
      status_r <= gbsp_pkg::ST_BAD;
      dist_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_ch.action == gbsp_pkg::ACT_SOLVE) begin
            sc_r[0] <= in_ch.start_c0;  sc_r[1] <= in_ch.start_c1;
            sc_r[2] <= in_ch.start_c2;  sc_r[3] <= in_ch.start_c3;
            ec_r[0] <= in_ch.end_c0;    ec_r[1] <= in_ch.end_c1;
            ec_r[2] <= in_ch.end_c2;    ec_r[3] <= in_ch.end_c3;
            cells_r <= CNT_W'(1);
            start_r <= '0;
            end_r   <= '0;
            dim_r   <= '0;
            sub_r   <= '0;
            state_r <= S_DIM;
          end
        end
        // four micro-steps per dimension through the shared multiplier
        S_DIM: begin
          case (sub_r)
            2'd0: begin
              if (dim_bad) begin
                status_r <= gbsp_pkg::ST_BAD;
                dist_r   <= '0;
                state_r  <= S_DONE;
              end else begin
                stride_r[dim_r] <= cells_r;
                sub_r <= 2'd1;
              end
            end
            2'd1: begin
              start_r <= start_r + mul_p[CELL_W-1:0];
              sub_r   <= 2'd2;
            end
            2'd2: begin
              end_r <= end_r + mul_p[CELL_W-1:0];
              sub_r <= 2'd3;
            end
            default: begin
              sub_r <= 2'd0;
              if (mul_p > PW'(MAX_CELLS)) begin
                status_r <= gbsp_pkg::ST_BAD;
                dist_r   <= '0;
                state_r  <= S_DONE;
              end else begin
                cells_r <= mul_p[CNT_W-1:0];
                dim_r   <= dim_r + 2'd1;
                if (dim_r == 2'(gbsp_pkg::DIMS - 1)) state_r <= S_WS_RD;
              end
            end
          endcase
        end
        S_WS_RD:  state_r <= S_WS_CHK;
        S_WS_CHK: begin
          if (wall_q_r[start_r[5:0]]) begin
            status_r <= gbsp_pkg::ST_WALL;
            dist_r   <= '0;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_WE_RD;
          end
        end
        S_WE_RD:  state_r <= S_WE_CHK;
        S_WE_CHK: begin
          if (wall_q_r[end_r[5:0]]) begin
            status_r <= gbsp_pkg::ST_WALL;
            dist_r   <= '0;
            state_r  <= S_DONE;
          end else begin
            clr_r   <= '0;
            tail_r  <= '0;   // seed lands in queue slot 0
            state_r <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) == MAP_WORDS - 1) state_r <= S_SEED;
        end
        S_SEED: begin
          head_r   <= '0;
          tail_r   <= CNT_W'(1);
          level_r  <= '0;
          left_r   <= CNT_W'(1);
          queued_r <= '0;
          state_r  <= S_POP_RD;
        end
        S_POP_RD: state_r <= S_POP_CHK;
        S_POP_CHK: begin
          cur_r <= q_q_r;
          if (q_q_r[CELL_W-1:0] == end_r) begin
            status_r <= gbsp_pkg::ST_FOUND;
            dist_r   <= sat_dist(level_r);
            state_r  <= S_DONE;
          end else begin
            cand_r  <= '0;
            state_r <= S_NB_RD;
          end
        end
        S_NB_RD: begin
          if (n_ok) begin
            nb_r    <= nb_c;
            state_r <= S_NB_CHK;
          end else begin
            cand_r <= cand_r + 3'd1;
            if (cand_r == 3'd7) state_r <= S_NEXT;
          end
        end
        S_NB_CHK: begin
          if (nb_hit) begin
            status_r <= gbsp_pkg::ST_FOUND;
            dist_r   <= sat_dist(level_r + 1'b1);
            state_r  <= S_DONE;
          end else begin
            if (nb_push) begin
              tail_r   <= tail_r + 1'b1;
              queued_r <= queued_r + 1'b1;
            end
            cand_r  <= cand_r + 3'd1;
            state_r <= (cand_r == 3'd7) ? S_NEXT : S_NB_RD;
          end
        end
        S_NEXT: begin
          head_r <= head_r + 1'b1;
          if (left_r == CNT_W'(1)) begin
            left_r   <= queued_r;
            queued_r <= '0;
            level_r  <= level_r + 1'b1;
          end else begin
            left_r <= left_r - 1'b1;
          end
          if (head_r + 1'b1 < tail_r) begin
            state_r <= S_POP_RD;
          end else begin
            status_r <= gbsp_pkg::ST_NOWAY;
            dist_r   <= '0;
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_ch.ready) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> tb/tb_top.sv
// Testbench for grid_bfs_shortest_path: directed table plus random mazes, BFS predictor.
module tb_top;

  localparam int MAP_WORDS = 1024;
  localparam int CELL_MAX  = 65536;

  // one input beat as the testbench sees it
  typedef struct {
    gbsp_pkg::action_t act;
    logic [9:0]  widx;
    logic [63:0] wall;
    logic [16:0] sc [gbsp_pkg::DIMS];
    logic [16:0] ec [gbsp_pkg::DIMS];
  } beat_t;

  typedef struct {
    gbsp_pkg::status_t st;
    logic [15:0] steps;
  } path_res_t;

  typedef enum logic [0:0] {ROW_SIZES, ROW_BEAT} row_kind_t;

  // directed stimulus row: either a new grid shape or one beat
  typedef struct {
    row_kind_t   kind;
    logic [16:0] sz [gbsp_pkg::DIMS];
    beat_t       b;
    bit          typed;
    path_res_t   res;
  } row_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [gbsp_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  gbsp_in_if  in_ch ();
  gbsp_out_if out_ch ();

  grid_bfs_shortest_path dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // shadow of the block: grid extents and wall bitmap
  logic [16:0] grid_ext [gbsp_pkg::DIMS];
  logic [63:0] wall_words [MAP_WORDS];

  path_res_t pending_paths [$];
  int        mismatches;
  int        burst_left;
  row_t      steer [$];

  always #4 clk = ~clk;

  // hard stop, far beyond the slowest legal run
  initial begin
    #40000000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("tb_top: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Breadth-first search over the shadow grid. Levels are counted the same
  // way the block counts them: a level closes when its last cell is popped.
  function automatic path_res_t bfs_distance(input beat_t b);
    path_res_t   r;
    longint unsigned ext [gbsp_pkg::DIMS];
    longint unsigned stride [gbsp_pkg::DIMS];
    longint unsigned cells, s, e, crd;
    int unsigned start_cell, end_cell, cur, nb, head;
    int unsigned level, left_now, queued_next;
    int unsigned frontier [$];
    bit seen [CELL_MAX];
    bit found;
    r.st = gbsp_pkg::ST_BAD;
    r.steps = '0;
    cells = 1;
    s = 0;
    e = 0;
    found = 0;
    for (int d = 0; d < gbsp_pkg::DIMS; d++) begin
      if (grid_ext[d] == 0 || grid_ext[d] > CELL_MAX) return r;
      if (b.sc[d] == 0 || b.sc[d] > grid_ext[d] || b.ec[d] == 0 || b.ec[d] > grid_ext[d])
        return r;
      ext[d] = grid_ext[d];
      stride[d] = cells;
      cells *= grid_ext[d];
      if (cells > CELL_MAX) return r;
      s += (b.sc[d] - 1) * stride[d];
      e += (b.ec[d] - 1) * stride[d];
    end
    start_cell = 32'(s);
    end_cell = 32'(e);
    // wall at either end wins over the search
    if (wall_words[start_cell >> 6][start_cell[5:0]] ||
        wall_words[end_cell >> 6][end_cell[5:0]]) begin
      r.st = gbsp_pkg::ST_WALL;
      return r;
    end
    frontier.push_back(start_cell);
    seen[start_cell] = 1;
    head = 0;
    level = 0;
    left_now = 1;
    queued_next = 0;
    while (head < frontier.size() && !found) begin
      cur = frontier[head];
      if (cur == end_cell) begin
        found = 1;
        break;
      end
      for (int d = 0; d < gbsp_pkg::DIMS && !found; d++) begin
        crd = (cur / stride[d]) % ext[d];
        for (int dir = 0; dir < 2; dir++) begin
          if (dir == 0 ? (crd + 1 < ext[d]) : (crd > 0)) begin
            nb = 32'(dir == 0 ? cur + stride[d] : cur - stride[d]);
            if (!wall_words[nb >> 6][nb[5:0]] && !seen[nb]) begin
              if (nb == end_cell) begin
                found = 1;
                level++;
                break;
              end
              seen[nb] = 1;
              frontier.push_back(nb);
              queued_next++;
            end
          end
        end
      end
      if (found) break;
      head++;
      left_now--;
      if (left_now == 0) begin
        left_now = queued_next;
        queued_next = 0;
        level++;
      end
    end
    if (found) begin
      r.st = gbsp_pkg::ST_FOUND;
      r.steps = level > 65535 ? 16'hFFFF : level[15:0];
    end else begin
      r.st = gbsp_pkg::ST_NOWAY;
    end
    return r;
  endfunction

  // APB write: setup, then access until pready, then idle
  task automatic size_write(input int d, input logic [16:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {gbsp_pkg::reg_idx_t'(d), 2'b00};
    pwdata  <= {15'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    grid_ext[d] = v;
    @(posedge clk);
  endtask

  // idle point: input channel quiet, every result back, load pipeline flushed
  task automatic drain_paths();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending_paths.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_grid(input logic [16:0] s0, s1, s2, s3);
    drain_paths();
    size_write(gbsp_pkg::REG_SIZE0, s0);
    size_write(gbsp_pkg::REG_SIZE1, s1);
    size_write(gbsp_pkg::REG_SIZE2, s2);
    size_write(gbsp_pkg::REG_SIZE3, s3);
  endtask

  // Sender: bursts of back-to-back beats, random non-empty gaps between them
  // so valid never drops and rises in the same step.
  task automatic send_beat(input beat_t b, input bit typed, input path_res_t typed_res);
    path_res_t r;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= b.act;
    in_ch.word_index <= b.widx;
    in_ch.wall_bits  <= b.wall;
    in_ch.start_c0   <= b.sc[0];
    in_ch.start_c1   <= b.sc[1];
    in_ch.start_c2   <= b.sc[2];
    in_ch.start_c3   <= b.sc[3];
    in_ch.end_c0     <= b.ec[0];
    in_ch.end_c1     <= b.ec[1];
    in_ch.end_c2     <= b.ec[2];
    in_ch.end_c3     <= b.ec[3];
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    // beat taken at this edge: update the shadow or queue the expected path
    if (b.act == gbsp_pkg::ACT_LOAD) begin
      wall_words[b.widx] = b.wall;
    end else begin
      r = typed ? typed_res : bfs_distance(b);
      pending_paths.push_back(r);
    end
  endtask

  function automatic beat_t rand_beat(input gbsp_pkg::action_t a);
    beat_t b;
    b.act  = a;
    b.widx = 10'($urandom_range(0, MAP_WORDS - 1));
    b.wall = {$urandom, $urandom};
    for (int d = 0; d < gbsp_pkg::DIMS; d++) begin
      b.sc[d] = 17'($urandom_range(0, 17'h1FFFF));
      b.ec[d] = 17'($urandom_range(0, 17'h1FFFF));
    end
    return b;
  endfunction

  // directed-table builders
  function automatic void add_sizes(input logic [16:0] s0, s1, s2, s3);
    row_t r;
    r.kind = ROW_SIZES;
    r.sz = '{s0, s1, s2, s3};
    r.typed = 0;
    steer.push_back(r);
  endfunction

  function automatic void add_load(input logic [9:0] idx, input logic [63:0] bits);
    row_t r;
    r.kind = ROW_BEAT;
    r.b = rand_beat(gbsp_pkg::ACT_LOAD);
    r.b.widx = idx;
    r.b.wall = bits;
    r.typed = 0;
    steer.push_back(r);
  endfunction

  function automatic void add_solve(input logic [16:0] s0, s1, s2, s3, e0, e1, e2, e3,
                                    input bit typed, input gbsp_pkg::status_t st,
                                    input logic [15:0] steps);
    row_t r;
    r.kind = ROW_BEAT;
    r.b = rand_beat(gbsp_pkg::ACT_SOLVE);
    r.b.sc = '{s0, s1, s2, s3};
    r.b.ec = '{e0, e1, e2, e3};
    r.typed = typed;
    r.res.st = st;
    r.res.steps = steps;
    steer.push_back(r);
  endfunction

  // Receiver: stall pattern switches periodically between always ready,
  // mostly ready, and long stalls.
  int stall_mode = 0;
  int stall_cyc = 0;
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 64 == 0) stall_mode <= $urandom_range(0, 2);
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 3) != 0;
        default: out_ch.ready <= $urandom_range(0, 7) == 0;
      endcase
    end
  end

  // result checker: values sampled at the edge, before this edge's updates
  always @(posedge clk) begin
    path_res_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_paths.size() == 0) begin
        report("unexpected result, status", out_ch.status, -1);
      end else begin
        w = pending_paths.pop_front();
        if (out_ch.status !== w.st) report("status", out_ch.status, w.st);
        if (out_ch.distance !== w.steps) report("distance", out_ch.distance, w.steps);
      end
    end
  end

  initial begin
    path_res_t none;
    beat_t b;
    logic [16:0] ext [gbsp_pkg::DIMS];
    int cells, nwords, pick;
    none.st = gbsp_pkg::ST_BAD;
    none.steps = '0;
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.action = gbsp_pkg::ACT_LOAD;
    in_ch.word_index = '0;
    in_ch.wall_bits = '0;
    in_ch.start_c0 = '0;
    in_ch.start_c1 = '0;
    in_ch.start_c2 = '0;
    in_ch.start_c3 = '0;
    in_ch.end_c0 = '0;
    in_ch.end_c1 = '0;
    in_ch.end_c2 = '0;
    in_ch.end_c3 = '0;
    mismatches = 0;
    burst_left = 0;
    for (int d = 0; d < gbsp_pkg::DIMS; d++) grid_ext[d] = 17'd1;
    foreach (wall_words[i]) wall_words[i] = '0;

    // Directed table. Reset sizes are all 1, so the grid is cell 0 alone.
    add_load(10'd0, 64'd0);
    add_solve(1, 1, 1, 1, 1, 1, 1, 1, 1, gbsp_pkg::ST_FOUND, 0);     // start equals end
    add_solve(0, 1, 1, 1, 1, 1, 1, 1, 1, gbsp_pkg::ST_BAD, 0);       // zero coordinate
    add_solve(1, 1, 1, 1, 1, 1, 2, 1, 1, gbsp_pkg::ST_BAD, 0);       // beyond extent
    add_load(10'd0, 64'd1);
    add_solve(1, 1, 1, 1, 1, 1, 1, 1, 1, gbsp_pkg::ST_WALL, 0);      // start on a wall
    // 8x8 maze in word 0
    add_sizes(8, 8, 1, 1);
    add_load(10'd0, 64'h0042_1870_2466_0C00);
    add_solve(1, 1, 1, 1, 8, 8, 1, 1, 0, none.st, 0);
    add_solve(8, 8, 1, 1, 1, 1, 1, 1, 0, none.st, 0);
    add_solve(3, 1, 1, 1, 5, 1, 1, 1, 0, none.st, 0);
    add_solve(1, 9, 1, 1, 1, 1, 1, 1, 1, gbsp_pkg::ST_BAD, 0);
    add_load(10'd0, 64'h0000_0000_0000_0102);            // corner sealed off
    add_solve(1, 1, 1, 1, 8, 8, 1, 1, 1, gbsp_pkg::ST_NOWAY, 0);
    // largest extent along dimension zero: top cell sits in word 1023
    add_sizes(17'd65536, 1, 1, 1);
    add_load(10'd1023, 64'd0);
    add_solve(17'd65536, 1, 1, 1, 17'd65536, 1, 1, 1, 1, gbsp_pkg::ST_FOUND, 0);
    add_solve(17'd65537, 1, 1, 1, 1, 1, 1, 1, 1, gbsp_pkg::ST_BAD, 0);
    add_load(10'd1023, 64'h8000_0000_0000_0000);
    add_solve(1, 1, 1, 1, 17'd65536, 1, 1, 1, 1, gbsp_pkg::ST_WALL, 0);  // end on a wall
    add_sizes(17'd65536, 2, 1, 1);                            // too many cells
    add_solve(1, 1, 1, 1, 1, 1, 1, 1, 1, gbsp_pkg::ST_BAD, 0);
    add_sizes(1, 1, 1, 17'd65536);
    add_load(10'd1023, 64'd0);
    add_solve(1, 1, 1, 17'd65536, 1, 1, 1, 17'd65536, 1, gbsp_pkg::ST_FOUND, 0);
    add_sizes(0, 1, 1, 1);                                    // zero extent
    add_solve(1, 1, 1, 1, 1, 1, 1, 1, 1, gbsp_pkg::ST_BAD, 0);
    add_sizes(17'h1FFFF, 1, 1, 1);                            // extent over limit
    add_solve(1, 1, 1, 1, 1, 1, 1, 1, 1, gbsp_pkg::ST_BAD, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steer[i]) begin
      if (steer[i].kind == ROW_SIZES)
        set_grid(steer[i].sz[0], steer[i].sz[1], steer[i].sz[2], steer[i].sz[3]);
      else
        send_beat(steer[i].b, steer[i].typed, steer[i].res);
    end

    // Random mazes: small grids, every word of the grid loaded before solving.
    for (int g = 0; g < 7; g++) begin
      cells = 1;
      for (int d = 0; d < gbsp_pkg::DIMS; d++) begin
        ext[d] = g == 0 ? (d == 0 ? 17'($urandom_range(64, 200)) : 17'd1)
                        : 17'($urandom_range(1, 4));
        cells *= ext[d];
      end
      set_grid(ext[0], ext[1], ext[2], ext[3]);
      nwords = (cells + 63) / 64;
      for (int w = 0; w < nwords; w++) begin
        b = rand_beat(gbsp_pkg::ACT_LOAD);
        b.widx = 10'(w);
        b.wall = {$urandom, $urandom} & {$urandom, $urandom};
        send_beat(b, 0, none);
      end
      for (int k = 0; k < 12; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          b = rand_beat(gbsp_pkg::ACT_LOAD);    // stray load anywhere in the bitmap
        end else if (pick < 4) begin
          b = rand_beat(gbsp_pkg::ACT_SOLVE);   // mostly out-of-range coordinates
        end else begin
          b = rand_beat(gbsp_pkg::ACT_SOLVE);
          for (int d = 0; d < gbsp_pkg::DIMS; d++) begin
            b.sc[d] = 17'($urandom_range(1, ext[d]));
            b.ec[d] = 17'($urandom_range(1, ext[d]));
          end
        end
        send_beat(b, 0, none);
      end
    end

    drain_paths();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_paths.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
